// ===== rtl/core/tsk_pkg.sv =====
// Shared types and constants for the topological sort core.
package tsk_pkg;

  localparam int VTX_W            = 6;    // vertex field width
  localparam int CFG_W            = 7;    // num_vertices register width
  localparam int MAX_VERTICES_DEF = 64;
  localparam int MAX_EDGES_DEF    = 256;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_SORT = 1'b1
  } tsk_func_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CNT_RD,
    S_CNT_CHK,
    S_CNT_WR,
    S_INIT_RD,
    S_INIT_CHK,
    S_POP_RD,
    S_POP_EMIT,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SCAN_WR,
    S_FIN
  } tsk_state_t;

  // Edge store control from the sequencer
  typedef struct packed {
    logic             load;
    logic [VTX_W-1:0] src;
    logic [VTX_W-1:0] dst;
    logic             rd;
    logic             clear;
  } tsk_edge_ctl_t;

  typedef struct packed {
    logic [VTX_W-1:0] src;
    logic [VTX_W-1:0] dst;
  } tsk_edge_t;

endpackage

// ===== rtl/core/tsk_if.sv =====
// Channel interfaces: edge/sort input, order output, vertex count config.
interface tsk_in_if import tsk_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             func;
  logic [VTX_W-1:0] src_vertex;
  logic [VTX_W-1:0] dst_vertex;

  modport source (output valid, func, src_vertex, dst_vertex, input ready);
  modport sink   (input valid, func, src_vertex, dst_vertex, output ready);
endinterface

interface tsk_out_if import tsk_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VTX_W-1:0] vertex;
  logic             vertex_valid;
  logic             last;
  logic             cycle_found;
  logic             edges_lost;

  modport source (output valid, vertex, vertex_valid, last, cycle_found, edges_lost,
                  input ready);
  modport sink   (input valid, vertex, vertex_valid, last, cycle_found, edges_lost,
                  output ready);
endinterface

interface tsk_cfg_if import tsk_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/core/tsk_edge_store.sv =====
// Edge list memory with fill count and drop flag.
module tsk_edge_store import tsk_pkg::*; #(
  parameter int  MAX_EDGES = MAX_EDGES_DEF,
  localparam int ECNT_W    = $clog2(MAX_EDGES + 1),
  localparam int EIDX_W    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CFG_W-1:0]  nv,
  input  tsk_edge_ctl_t     ctl,
  input  logic [EIDX_W-1:0] rd_addr,
  output tsk_edge_t         rd_data,
  output logic [ECNT_W-1:0] edge_cnt,
  output logic              dropped
);

  tsk_edge_t         mem [MAX_EDGES];
  tsk_edge_t         rd_data_r;
  logic [ECNT_W-1:0] cnt_r;
  logic              dropped_r;
  logic              full;
  logic              reject;

  assign full   = (cnt_r == ECNT_W'(MAX_EDGES));
  assign reject = ({1'b0, ctl.src} >= nv) || ({1'b0, ctl.dst} >= nv) || full;

  always_ff @(posedge clk) begin
    if (ctl.load && !reject) begin
      mem[cnt_r[EIDX_W-1:0]] <= '{src: ctl.src, dst: ctl.dst};
    end
    if (ctl.rd) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      dropped_r <= 1'b0;
    end else if (ctl.clear) begin
      cnt_r     <= '0;
      dropped_r <= 1'b0;
    end else if (ctl.load) begin
      if (reject) begin
        dropped_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  assign rd_data  = rd_data_r;
  assign edge_cnt = cnt_r;
  assign dropped  = dropped_r;

endmodule

// ===== rtl/core/topological_sort_kahn_core.sv =====
// Topological sort core (Kahn): edge loader, sort sequencer, order output.
//
// in_ch  : one transaction per item. func=0 stores edge src_vertex -> dst_vertex in
//          load order (one per cycle while idle); edges naming a vertex at or above
//          the vertex count, or arriving with the store full, are dropped and flagged.
//          func=1 starts a sort run; in_ch.ready stays low until the run completes.
// out_ch : one transaction per emitted vertex, in topological order. The final one has
//          last=1 with cycle_found and edges_lost; a run that emits nothing gives one
//          transaction with vertex_valid=0, last=1.
// cfg_ch : writes num_vertices (values above MAX_VERTICES act as MAX_VERTICES).
//          Always ready; write only between runs.
// Sort   : every in-degree change is a read, update, write pass through the in-degree
//          memory and its shared +/-1 unit, and each popped vertex rescans the whole
//          edge list. Output stalls hold a run.
// Reset  : rst_n (sync) empties the edge list, clears the drop flag, sets the vertex
//          count to 64 and idles the sequencer. No memory clearing pass is needed.
// Stall  : results sit in one output register; while it is full and out_ch.ready is low
//          the sequencer holds before loading the next result.
module topological_sort_kahn_core import tsk_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = MAX_EDGES_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  tsk_in_if.sink    in_ch,
  tsk_out_if.source out_ch,
  tsk_cfg_if.sink   cfg_ch
);

  localparam int ECNT_W = $clog2(MAX_EDGES + 1);
  localparam int EIDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int VIDX_W = $clog2(MAX_VERTICES);
  localparam int DEG_W  = $clog2(MAX_EDGES + 1);

  tsk_state_t state_r, state_nxt;

  // config
  logic [CFG_W-1:0] cfg_r;
  logic [CFG_W-1:0] nv;

  // edge store
  tsk_edge_ctl_t     edge_ctl;
  logic [EIDX_W-1:0] edge_raddr;
  tsk_edge_t         edge_q;
  logic [ECNT_W-1:0] edge_cnt;
  logic              edge_dropped;

  // sequencer counters
  logic [ECNT_W-1:0] eidx_r;
  logic [CNT_W-1:0]  vidx_r;
  logic [CNT_W-1:0]  head_r;
  logic [CNT_W-1:0]  tail_r;
  logic [CNT_W-1:0]  emit_r;
  logic              lost_r;
  logic [VTX_W-1:0]  pend_r;
  logic              pend_vld_r;

  // in-degree memory, valid bits stand in for the per-run clear
  logic [DEG_W-1:0]        deg_mem [MAX_VERTICES];
  logic [DEG_W-1:0]        deg_mem_q;
  logic [MAX_VERTICES-1:0] deg_vld_r;
  logic [VIDX_W-1:0]       deg_raddr_r;
  logic [DEG_W-1:0]        deg_q;
  logic [DEG_W-1:0]        deg_upd;

  // ready queue memory
  logic [VTX_W-1:0] q_mem [MAX_VERTICES];
  logic [VTX_W-1:0] q_q;

  // output register
  logic             out_vld_r;
  logic [VTX_W-1:0] out_vertex_r;
  logic             out_vvld_r;
  logic             out_last_r;
  logic             out_cyc_r;
  logic             out_lost_r;
  logic             out_free;

  // strobes
  logic              in_acc;
  logic              run_start;
  logic              edge_ok;
  logic              edge_match;
  logic              eidx_inc;
  logic              eidx_clr;
  logic              vidx_inc;
  logic              head_inc;
  logic              set_lost;
  logic              deg_rd;
  logic [VIDX_W-1:0] deg_raddr;
  logic              deg_we;
  logic              q_rd;
  logic              q_we;
  logic [VTX_W-1:0]  q_wdata;
  logic              pend_load;
  logic              out_load;
  logic              out_final;
  logic              tail_room;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      cfg_r <= cfg_ch.data;
    end
  end
  assign cfg_ch.ready = 1'b1;
  assign nv = (cfg_r > CFG_W'(MAX_VERTICES)) ? CFG_W'(MAX_VERTICES) : cfg_r;

  // ---------------------------------------------------------------- input
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign run_start   = in_acc && (in_ch.func == FUNC_SORT);

  tsk_edge_store #(.MAX_EDGES(MAX_EDGES)) u_edges (
    .clk      (clk),
    .rst_n    (rst_n),
    .nv       (nv),
    .ctl      (edge_ctl),
    .rd_addr  (edge_raddr),
    .rd_data  (edge_q),
    .edge_cnt (edge_cnt),
    .dropped  (edge_dropped)
  );

  // ---------------------------------------------------------------- datapath views
  assign edge_ok    = ({1'b0, edge_q.src} < nv) && ({1'b0, edge_q.dst} < nv);
  assign edge_match = edge_ok && (edge_q.src == pend_r);
  assign deg_q      = deg_vld_r[deg_raddr_r] ? deg_mem_q : '0;
  // shared in-degree unit: +1 while counting, -1 while scanning
  assign deg_upd    = deg_q + ((state_r == S_CNT_WR) ? DEG_W'(1) : {DEG_W{1'b1}});
  assign tail_room  = (tail_r != CNT_W'(MAX_VERTICES));
  assign out_free   = !out_vld_r || out_ch.ready;

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (run_start) state_nxt = S_CNT_RD;
      S_CNT_RD:   state_nxt = (eidx_r == edge_cnt) ? S_INIT_RD : S_CNT_CHK;
      S_CNT_CHK:  state_nxt = edge_ok ? S_CNT_WR : S_CNT_RD;
      S_CNT_WR:   state_nxt = S_CNT_RD;
      S_INIT_RD:  state_nxt = (CFG_W'(vidx_r) == nv) ? S_POP_RD : S_INIT_CHK;
      S_INIT_CHK: state_nxt = S_INIT_RD;
      S_POP_RD:   state_nxt = (head_r < tail_r) ? S_POP_EMIT : S_FIN;
      S_POP_EMIT: if (!pend_vld_r || out_free) state_nxt = S_SCAN_RD;
      S_SCAN_RD:  state_nxt = (eidx_r == edge_cnt) ? S_POP_RD : S_SCAN_CHK;
      S_SCAN_CHK: state_nxt = edge_match ? S_SCAN_WR : S_SCAN_RD;
      S_SCAN_WR:  state_nxt = S_SCAN_RD;
      S_FIN:      if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- control outputs
  always_comb begin
    edge_ctl       = '0;
    edge_ctl.load  = in_acc && (in_ch.func == FUNC_LOAD);
    edge_ctl.src   = in_ch.src_vertex;
    edge_ctl.dst   = in_ch.dst_vertex;
    edge_raddr     = eidx_r[EIDX_W-1:0];
    eidx_inc       = 1'b0;
    eidx_clr       = 1'b0;
    vidx_inc       = 1'b0;
    head_inc       = 1'b0;
    set_lost       = 1'b0;
    deg_rd         = 1'b0;
    deg_raddr      = edge_q.dst[VIDX_W-1:0];
    deg_we         = 1'b0;
    q_rd           = 1'b0;
    q_we           = 1'b0;
    q_wdata        = VTX_W'(deg_raddr_r);
    pend_load      = 1'b0;
    out_load       = 1'b0;
    out_final      = 1'b0;
    case (state_r)
      S_CNT_RD: begin
        edge_ctl.rd = (eidx_r != edge_cnt);
      end
      S_CNT_CHK: begin
        if (edge_ok) begin
          deg_rd = 1'b1;
        end else begin
          set_lost = 1'b1;
          eidx_inc = 1'b1;
        end
      end
      S_CNT_WR: begin
        deg_we   = 1'b1;
        eidx_inc = 1'b1;
      end
      S_INIT_RD: begin
        deg_rd    = (CFG_W'(vidx_r) != nv);
        deg_raddr = vidx_r[VIDX_W-1:0];
      end
      S_INIT_CHK: begin
        q_we     = (deg_q == '0) && tail_room;
        q_wdata  = VTX_W'(vidx_r);
        vidx_inc = 1'b1;
      end
      S_POP_RD: begin
        q_rd     = (head_r < tail_r);
        head_inc = (head_r < tail_r);
      end
      S_POP_EMIT: begin
        if (!pend_vld_r || out_free) begin
          out_load  = pend_vld_r;
          pend_load = 1'b1;
          eidx_clr  = 1'b1;
        end
      end
      S_SCAN_RD: begin
        edge_ctl.rd = (eidx_r != edge_cnt);
      end
      S_SCAN_CHK: begin
        if (edge_match) begin
          deg_rd = 1'b1;
        end else begin
          eidx_inc = 1'b1;
        end
      end
      S_SCAN_WR: begin
        deg_we   = (deg_q != '0);
        q_we     = (deg_q != '0) && (deg_upd == '0) && tail_room;
        eidx_inc = 1'b1;
      end
      S_FIN: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_final      = 1'b1;
          edge_ctl.clear = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------- memories
  always_ff @(posedge clk) begin
    if (deg_we) begin
      deg_mem[deg_raddr_r] <= deg_upd;
    end
    if (deg_rd) begin
      deg_mem_q   <= deg_mem[deg_raddr];
      deg_raddr_r <= deg_raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[tail_r[VIDX_W-1:0]] <= q_wdata;
    end
    if (q_rd) begin
      q_q <= q_mem[head_r[VIDX_W-1:0]];
    end
  end

  // ---------------------------------------------------------------- sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      eidx_r     <= '0;
      vidx_r     <= '0;
      head_r     <= '0;
      tail_r     <= '0;
      emit_r     <= '0;
      lost_r     <= 1'b0;
      pend_vld_r <= 1'b0;
      deg_vld_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (run_start) begin
        eidx_r     <= '0;
        vidx_r     <= '0;
        head_r     <= '0;
        tail_r     <= '0;
        emit_r     <= '0;
        lost_r     <= edge_dropped;
        pend_vld_r <= 1'b0;
        deg_vld_r  <= '0;
      end else begin
        if (eidx_clr) begin
          eidx_r <= '0;
        end else if (eidx_inc) begin
          eidx_r <= eidx_r + 1'b1;
        end
        if (vidx_inc) vidx_r <= vidx_r + 1'b1;
        if (head_inc) head_r <= head_r + 1'b1;
        if (q_we)     tail_r <= tail_r + 1'b1;
        if (set_lost) lost_r <= 1'b1;
        if (deg_we)   deg_vld_r[deg_raddr_r] <= 1'b1;
        if (pend_load) begin
          pend_vld_r <= 1'b1;
          emit_r     <= emit_r + 1'b1;
        end
      end
    end
  end

  // popped vertex is held back until we know whether it is the final result
  always_ff @(posedge clk) begin
    if (pend_load) begin
      pend_r <= q_q;
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_vertex_r <= (out_final && !pend_vld_r) ? '0 : pend_r;
      out_vvld_r   <= pend_vld_r;
      out_last_r   <= out_final;
      out_cyc_r    <= out_final && (CFG_W'(emit_r) < nv);
      out_lost_r   <= out_final && lost_r;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.vertex       = out_vertex_r;
  assign out_ch.vertex_valid = out_vvld_r;
  assign out_ch.last         = out_last_r;
  assign out_ch.cycle_found  = out_cyc_r;
  assign out_ch.edges_lost   = out_lost_r;

endmodule
